FILE: rtl/rll_pkg.sv
// Shared types and constants for the resonant ladder low-pass unit.
// Used by the interfaces, register block, controller, datapath and top level.
package rll_pkg;

	localparam int SAMPLE_BITS_DEF = 16;

	// Register map
	localparam int ADDR_BITS = 4;
	localparam int DATA_BITS = 32;
	localparam int CFG_BITS  = 7;
	localparam logic [1:0] REG_WET       = 2'd0;
	localparam logic [1:0] REG_CUTOFF    = 2'd1;
	localparam logic [1:0] REG_RESONANCE = 2'd2;

	// Filter constants
	localparam int MIX_FULL    = 100;
	localparam int ALPHA_BASE  = 160;
	localparam int ALPHA_STEP  = 280;
	localparam int ALPHA_MAX   = 28800;
	localparam int FB_GAIN     = 122000 / MIX_FULL;
	localparam int KNEE        = 192;
	localparam int BEND        = 384;
	localparam int FRAC_BITS   = 15;
	localparam int ALPHA_BITS  = 15;
	localparam int FB_BITS     = 17;
	localparam int DRV_BITS    = 11;
	localparam int DIV_STEPS   = 9;
	localparam int LADDER_LEN  = 4;
	localparam int CNT_BITS    = 4;

	// Datapath operations
	localparam int OP_BITS = 4;
	localparam logic [OP_BITS-1:0] OP_NONE = 4'd0;
	localparam logic [OP_BITS-1:0] OP_FB   = 4'd1;
	localparam logic [OP_BITS-1:0] OP_CLIP = 4'd2;
	localparam logic [OP_BITS-1:0] OP_DIV  = 4'd3;
	localparam logic [OP_BITS-1:0] OP_DRV  = 4'd4;
	localparam logic [OP_BITS-1:0] OP_SMUL = 4'd5;
	localparam logic [OP_BITS-1:0] OP_SUPD = 4'd6;
	localparam logic [OP_BITS-1:0] OP_MIXA = 4'd7;
	localparam logic [OP_BITS-1:0] OP_MIXB = 4'd8;
	localparam logic [OP_BITS-1:0] OP_MIXC = 4'd9;
	localparam logic [OP_BITS-1:0] OP_MIXD = 4'd10;
	localparam logic [OP_BITS-1:0] OP_MIXE = 4'd11;

	typedef struct packed {
		logic [CFG_BITS-1:0] wet;
		logic [CFG_BITS-1:0] cutoff;
		logic [CFG_BITS-1:0] resonance;
	} rll_cfg_t;

	typedef struct packed {
		logic               load;
		logic [OP_BITS-1:0] op;
		logic               out_load;
	} rll_cmd_t;

	typedef struct packed {
		logic amt_zero;
		logic knee_over;
	} rll_stat_t;

endpackage

FILE: rtl/rll_in_if.sv
// Input sample channel: valid/ready handshake carrying one sample per request.
// Depends on rll_pkg for the default sample width.
interface rll_in_if #(
	parameter int SAMPLE_BITS = rll_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

FILE: rtl/rll_out_if.sv
// Output sample channel: valid/ready handshake carrying one mixed sample per request.
// Depends on rll_pkg for the default sample width.
interface rll_out_if #(
	parameter int SAMPLE_BITS = rll_pkg::SAMPLE_BITS_DEF
) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: rtl/resonant_ladder_lowpass_unit.sv
// Resonant four-pole ladder low-pass with dry/wet mix, APB configuration.
// Each sample runs feedback, soft clip, ladder and mix; wet_amount 0 bypasses the filter.
// A new sample is accepted only after the previous result is loaded for output, as all steps
// share the single multiplier and the 9-step soft-clip divider.
// Reset (arst_n low, asynchronous) clears ladder stages and control; registers
// return to wet_amount 0, cutoff 1, resonance 0.
module resonant_ladder_lowpass_unit #(
	parameter int SAMPLE_BITS = rll_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	rll_in_if.sink                        din,
	rll_out_if.source                     dout,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [rll_pkg::ADDR_BITS-1:0] paddr,
	input  logic [rll_pkg::DATA_BITS-1:0] pwdata,
	output logic [rll_pkg::DATA_BITS-1:0] prdata,
	output logic                          pready
);
	rll_pkg::rll_cfg_t  cfg;
	rll_pkg::rll_cmd_t  cmd;
	rll_pkg::rll_stat_t stat;
	logic               in_ready;
	logic               out_valid;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	rll_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rll_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (dout.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rll_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg        (cfg),
		.sample_in  (din.sample_in),
		.stat       (stat),
		.sample_out (sample_out)
	);

	assign din.ready       = in_ready;
	assign dout.valid      = out_valid;
	assign dout.sample_out = sample_out;

endmodule

FILE: rtl/rll_cfg.sv
// APB register block: wet_amount, cutoff and resonance registers.
// Depends on rll_pkg for the register map and the configuration struct.
module rll_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rll_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [rll_pkg::DATA_BITS-1:0]  pwdata,
	output logic [rll_pkg::DATA_BITS-1:0]  prdata,
	output logic                           pready,
	output rll_pkg::rll_cfg_t              cfg
);
	logic [rll_pkg::CFG_BITS-1:0] wet_q;
	logic [rll_pkg::CFG_BITS-1:0] cutoff_q;
	logic [rll_pkg::CFG_BITS-1:0] resonance_q;
	logic [1:0]                   idx;
	logic                         wr;

	assign idx    = paddr[rll_pkg::ADDR_BITS-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wet_q       <= '0;
			cutoff_q    <= rll_pkg::CFG_BITS'(1);
			resonance_q <= '0;
		end else if (wr) begin
			case (idx)
				rll_pkg::REG_WET:       wet_q       <= pwdata[rll_pkg::CFG_BITS-1:0];
				rll_pkg::REG_CUTOFF:    cutoff_q    <= pwdata[rll_pkg::CFG_BITS-1:0];
				rll_pkg::REG_RESONANCE: resonance_q <= pwdata[rll_pkg::CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			rll_pkg::REG_WET:       prdata = rll_pkg::DATA_BITS'(wet_q);
			rll_pkg::REG_CUTOFF:    prdata = rll_pkg::DATA_BITS'(cutoff_q);
			rll_pkg::REG_RESONANCE: prdata = rll_pkg::DATA_BITS'(resonance_q);
			default:                prdata = '0;
		endcase
	end

	assign cfg.wet       = wet_q;
	assign cfg.cutoff    = cutoff_q;
	assign cfg.resonance = resonance_q;

endmodule

FILE: rtl/rll_ctrl.sv
// Controller: sequences one sample through feedback, soft clip, ladder and mix, or bypasses them when wet is 0.
// Depends on rll_pkg for the command and status structs and operation codes.
module rll_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  rll_pkg::rll_stat_t stat,
	output rll_pkg::rll_cmd_t  cmd
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_FB   = 4'd1;
	localparam logic [3:0] ST_CLIP = 4'd2;
	localparam logic [3:0] ST_DIV  = 4'd3;
	localparam logic [3:0] ST_DRV  = 4'd4;
	localparam logic [3:0] ST_SMUL = 4'd5;
	localparam logic [3:0] ST_SUPD = 4'd6;
	localparam logic [3:0] ST_MIXA = 4'd7;
	localparam logic [3:0] ST_MIXB = 4'd8;
	localparam logic [3:0] ST_MIXC = 4'd9;
	localparam logic [3:0] ST_MIXD = 4'd10;
	localparam logic [3:0] ST_MIXE = 4'd11;
	localparam logic [3:0] ST_DONE = 4'd12;

	localparam logic [rll_pkg::CNT_BITS-1:0] DIV_LAST =
		rll_pkg::CNT_BITS'(rll_pkg::DIV_STEPS - 1);
	localparam logic [rll_pkg::CNT_BITS-1:0] STG_LAST =
		rll_pkg::CNT_BITS'(rll_pkg::LADDER_LEN - 1);

	logic [3:0]                   state_q, state_d;
	logic [rll_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
	logic                         out_valid_q, out_valid_d;
	logic                         out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		cnt_d   = cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.amt_zero ? ST_DONE : ST_FB;
				end
			end
			ST_FB: begin
				cmd.op  = rll_pkg::OP_FB;
				state_d = ST_CLIP;
			end
			ST_CLIP: begin
				cmd.op  = rll_pkg::OP_CLIP;
				cnt_d   = '0;
				state_d = stat.knee_over ? ST_DIV : ST_SMUL;
			end
			ST_DIV: begin
				cmd.op = rll_pkg::OP_DIV;
				cnt_d  = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_DRV;
				end
			end
			ST_DRV: begin
				cmd.op  = rll_pkg::OP_DRV;
				cnt_d   = '0;
				state_d = ST_SMUL;
			end
			ST_SMUL: begin
				cmd.op  = rll_pkg::OP_SMUL;
				state_d = ST_SUPD;
			end
			ST_SUPD: begin
				cmd.op = rll_pkg::OP_SUPD;
				if (cnt_q == STG_LAST) begin
					cnt_d   = '0;
					state_d = ST_MIXA;
				end else begin
					cnt_d   = cnt_q + 1'b1;
					state_d = ST_SMUL;
				end
			end
			ST_MIXA: begin
				cmd.op  = rll_pkg::OP_MIXA;
				state_d = ST_MIXB;
			end
			ST_MIXB: begin
				cmd.op  = rll_pkg::OP_MIXB;
				state_d = ST_MIXC;
			end
			ST_MIXC: begin
				cmd.op  = rll_pkg::OP_MIXC;
				state_d = ST_MIXD;
			end
			ST_MIXD: begin
				cmd.op  = rll_pkg::OP_MIXD;
				state_d = ST_MIXE;
			end
			ST_MIXE: begin
				cmd.op  = rll_pkg::OP_MIXE;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= DIV_LAST)
		else $error("divider step count overran");

	a_filter_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !stat.amt_zero |=> state_q == ST_FB)
		else $error("filtered request did not start at feedback step");

	a_ladder_end: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SUPD && cnt_q == STG_LAST |=> state_q == ST_MIXA)
		else $error("ladder pass did not end after last stage");

	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q && state_q == ST_IDLE)
		else $error("result load did not raise output valid");

endmodule

FILE: rtl/rll_datapath.sv
// Datapath: shared multiplier, soft-clip divider, ladder stages and dry/wet mix.
// Depends on rll_pkg for constants, operation codes and command/status structs.
module rll_datapath #(
	parameter int SAMPLE_BITS = rll_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rll_pkg::rll_cmd_t             cmd,
	input  rll_pkg::rll_cfg_t             cfg,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	output rll_pkg::rll_stat_t            stat,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);
	localparam int W      = SAMPLE_BITS;
	localparam int EW     = W + 4;
	localparam int MW     = W + 8;
	localparam int PW     = 2 * MW;
	localparam int NW     = W + 13;
	localparam int MIX_SH = W + 13;
	localparam int CB     = rll_pkg::CFG_BITS;
	localparam int FB     = rll_pkg::FRAC_BITS;
	localparam int DS     = rll_pkg::DIV_STEPS;
	localparam longint unsigned RECIP_L =
		((64'd1 << MIX_SH) + rll_pkg::MIX_FULL - 1) / rll_pkg::MIX_FULL;
	localparam logic signed [MW-1:0] RECIP = MW'(RECIP_L);
	localparam logic signed [W+1:0] LIM_P = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [W+1:0] LIM_N = -LIM_P;
	localparam logic [CB-1:0] FULL = CB'(rll_pkg::MIX_FULL);

	logic signed [W-1:0]  x_q, y_q, acc_q, out_q, tgt_q;
	logic signed [W-1:0]  s_q [rll_pkg::LADDER_LEN];
	logic [CB-1:0]        amt_q;
	logic [rll_pkg::ALPHA_BITS-1:0] alpha_q;
	logic [rll_pkg::FB_BITS-1:0]    fb_q;
	logic signed [PW-1:0] prod_q;
	logic                 neg_q;
	logic [NW-1:0]        rem_q, den_q;
	logic [DS-1:0]        quo_q;

	logic [CB-1:0]        amt_sat, cut_sat, res_sat;
	logic [rll_pkg::ALPHA_BITS-1:0] alpha_raw, alpha_new;
	logic [rll_pkg::FB_BITS-1:0]    fb_new;
	logic signed [EW-1:0] e_val;
	logic [EW-1:0]        e_abs, d_val;
	logic                 knee_over;
	logic signed [W:0]    diff;
	logic signed [MW-1:0] ma, mb;
	logic [PW-1:0]        prod_abs;
	logic signed [W-1:0]  mix_q;
	logic signed [W+1:0]  upd_sum;
	logic signed [W-1:0]  upd_val;
	logic [DS:0]          drv_mag;
	logic signed [W-1:0]  drv_val;

	// Saturate register values at request load
	always_comb begin
		amt_sat = (cfg.wet > FULL) ? FULL : cfg.wet;
		res_sat = (cfg.resonance > FULL) ? FULL : cfg.resonance;
		if (cfg.cutoff == '0) begin
			cut_sat = CB'(1);
		end else if (cfg.cutoff > FULL) begin
			cut_sat = FULL;
		end else begin
			cut_sat = cfg.cutoff;
		end
		alpha_raw = rll_pkg::ALPHA_BITS'(rll_pkg::ALPHA_BASE
			+ rll_pkg::ALPHA_STEP * int'(cut_sat));
		alpha_new = (alpha_raw > rll_pkg::ALPHA_BITS'(rll_pkg::ALPHA_MAX))
			? rll_pkg::ALPHA_BITS'(rll_pkg::ALPHA_MAX) : alpha_raw;
		fb_new = rll_pkg::FB_BITS'(rll_pkg::FB_GAIN * int'(res_sat));
	end

	// Soft-clip input: sample minus floored feedback
	always_comb begin
		e_val     = EW'(x_q) - $signed(prod_q[FB +: EW]);
		e_abs     = e_val[EW-1] ? EW'(-e_val) : EW'(e_val);
		knee_over = e_abs > EW'(rll_pkg::KNEE);
		d_val     = e_abs - EW'(rll_pkg::KNEE);
	end

	assign stat.amt_zero  = (cfg.wet == '0);
	assign stat.knee_over = knee_over;

	// Shared multiplier operand select
	always_comb begin
		diff     = (W+1)'(tgt_q) - (W+1)'(s_q[0]);
		prod_abs = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
		case (cmd.op)
			rll_pkg::OP_FB: begin
				ma = MW'(s_q[rll_pkg::LADDER_LEN-1]);
				mb = MW'($signed({1'b0, fb_q}));
			end
			rll_pkg::OP_SMUL: begin
				ma = MW'($signed({1'b0, alpha_q}));
				mb = MW'(diff);
			end
			rll_pkg::OP_MIXA: begin
				ma = MW'(x_q);
				mb = MW'($signed({1'b0, FULL - amt_q}));
			end
			rll_pkg::OP_MIXC: begin
				ma = MW'(s_q[rll_pkg::LADDER_LEN-1]);
				mb = MW'($signed({1'b0, amt_q}));
			end
			rll_pkg::OP_MIXB, rll_pkg::OP_MIXD: begin
				ma = $signed(prod_abs[MW-1:0]);
				mb = RECIP;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	always_comb begin
		mix_q   = neg_q ? -$signed(prod_q[MIX_SH +: W]) : $signed(prod_q[MIX_SH +: W]);
		upd_sum = (W+2)'(s_q[0]) + (W+2)'($signed(prod_q[FB +: W+1]));
		if (upd_sum > LIM_P) begin
			upd_val = W'(LIM_P);
		end else if (upd_sum < LIM_N) begin
			upd_val = W'(LIM_N);
		end else begin
			upd_val = W'(upd_sum);
		end
		drv_mag = (DS+1)'(rll_pkg::KNEE) + (DS+1)'(quo_q);
		drv_val = neg_q ? -W'($signed({1'b0, drv_mag})) : W'($signed({1'b0, drv_mag}));
	end

	// Ladder state: rotate one stage per update so stage 3 lands back at the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rll_pkg::LADDER_LEN; i++) begin
				s_q[i] <= '0;
			end
		end else if (cmd.op == rll_pkg::OP_SUPD) begin
			for (int i = 0; i < rll_pkg::LADDER_LEN - 1; i++) begin
				s_q[i] <= s_q[i+1];
			end
			s_q[rll_pkg::LADDER_LEN-1] <= upd_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= sample_in;
			y_q     <= sample_in;
			amt_q   <= amt_sat;
			alpha_q <= alpha_new;
			fb_q    <= fb_new;
		end
		case (cmd.op)
			rll_pkg::OP_FB, rll_pkg::OP_SMUL, rll_pkg::OP_MIXA: begin
				prod_q <= ma * mb;
			end
			rll_pkg::OP_MIXB, rll_pkg::OP_MIXD: begin
				neg_q  <= prod_q[PW-1];
				prod_q <= ma * mb;
			end
			rll_pkg::OP_MIXC: begin
				acc_q  <= mix_q;
				prod_q <= ma * mb;
			end
			rll_pkg::OP_MIXE: begin
				y_q <= acc_q + mix_q;
			end
			rll_pkg::OP_CLIP: begin
				neg_q <= e_val[EW-1];
				tgt_q <= W'(e_val);
				rem_q <= NW'(d_val) * NW'(rll_pkg::BEND);
				den_q <= (NW'(d_val) + NW'(rll_pkg::BEND)) << (DS - 1);
				quo_q <= '0;
			end
			rll_pkg::OP_DIV: begin
				if (rem_q >= den_q) begin
					rem_q <= rem_q - den_q;
					quo_q <= {quo_q[DS-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[DS-2:0], 1'b0};
				end
				den_q <= den_q >> 1;
			end
			rll_pkg::OP_DRV: begin
				tgt_q <= drv_val;
			end
			rll_pkg::OP_SUPD: begin
				tgt_q <= upd_val;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			out_q <= y_q;
		end
	end

	assign sample_out = out_q;

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == rll_pkg::OP_DRV |-> quo_q < DS'(rll_pkg::BEND))
		else $error("soft clip quotient out of range");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		(W+2)'(s_q[rll_pkg::LADDER_LEN-1]) >= LIM_N)
		else $error("last ladder stage below limit");

endmodule
